// ===== rtl/multi_device_io_request_scheduler_defines.svh =====
// ----------------------------------------------------------------------------
// multi_device_io_request_scheduler_defines
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef MULTI_DEVICE_IO_REQUEST_SCHEDULER_DEFINES_SVH
`define MULTI_DEVICE_IO_REQUEST_SCHEDULER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MDIOS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mdios check failed");

// next-cycle implication, checked outside reset
`define MDIOS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mdios check failed");

`endif

// ===== rtl/mdios_pkg.sv =====
// ----------------------------------------------------------------------------
// mdios_pkg
// shared constants and codes of the i/o request scheduler
// ----------------------------------------------------------------------------
package mdios_pkg;

    localparam int NUM_DEV         = 5;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ENTRY_W         = 32;
    localparam logic [15:0] LAT_RESET   = 16'd10;
    localparam logic [15:0] SCALE_RESET = 16'd256;

    typedef enum logic [2:0] {
        OP_REQ   = 3'd0,
        OP_TIMED = 3'd1,
        OP_CANCEL= 3'd2,
        OP_TICK  = 3'd3,
        OP_QUERY = 3'd4
    } t_op;

    localparam logic [2:0] K_ACCEPT = 3'd0;
    localparam logic [2:0] K_REJECT = 3'd1;
    localparam logic [2:0] K_DONE   = 3'd2;
    localparam logic [2:0] K_TICK   = 3'd3;
    localparam logic [2:0] K_QUERY  = 3'd4;

    localparam logic [2:0] CFG_SCALE = 3'd5;

endpackage

// ===== rtl/mdios_qram.sv =====
// ----------------------------------------------------------------------------
// mdios_qram
// queue entry memory, one write and one registered read port
// ----------------------------------------------------------------------------
module mdios_qram
    import mdios_pkg::*;
#(
    parameter int DEPTH = NUM_DEV * QUEUE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [ENTRY_W-1:0] i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output logic [ENTRY_W-1:0] o_rdata
);

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/multi_device_io_request_scheduler.sv =====
// a request passes S_MUL and S_REQ before its result; a bad device or an unknown
// operation goes straight to its result; query walks the devices and their queued
// entries until a hit; tick walks every device, and a completion may start a queued
// request; cancel walks every device and its queued entries and restarts a freed slot;
// one transaction in flight, the next accepted the cycle after the last result registers
// reset (i_rst_n low, synchronous) clears busy, counts, valid; reloads config regs
// ----------------------------------------------------------------------------
// multi_device_io_request_scheduler
// five device slots with countdowns and circular request queues in memory
// ----------------------------------------------------------------------------
module multi_device_io_request_scheduler
    import mdios_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[2:0], pid[18:3], device[21:19], duration[37:22], zero[39:38]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // kind[2:0], out_pid[18:3], out_device[21:19], waiting[22], zero[23]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int MEM_D = NUM_DEV * QUEUE_DEPTH;
    localparam int AW    = (MEM_D > 1) ? $clog2(MEM_D) : 1;
    localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam logic [2:0]    LAST_DEV = 3'(NUM_DEV - 1);
    localparam logic [CW-1:0] QD_C     = CW'(QUEUE_DEPTH);
    localparam logic [PW:0]   QD_P     = (PW + 1)'(QUEUE_DEPTH);
    localparam logic [AW-1:0] QD_A     = AW'(QUEUE_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE, S_MUL, S_REQ, S_OUT,
        S_SRD, S_SLD,
        S_CRD, S_CCMP, S_CFREE, S_CNEXT,
        S_TDEV, S_TSTART, S_TNEXT,
        S_QDEV, S_QRD, S_QCMP
    } t_state;

    t_state r_state, r_ret, r_sret;

    logic [15:0]   r_lat [NUM_DEV];
    logic [15:0]   r_scale;
    logic          r_busy [NUM_DEV];
    logic [15:0]   r_cpid [NUM_DEV];
    logic [15:0]   r_rem  [NUM_DEV];
    logic [PW-1:0] r_head [NUM_DEV];
    logic [CW-1:0] r_cnt  [NUM_DEV];

    logic [2:0]    r_op;
    logic [15:0]   r_pid;
    logic [2:0]    r_dev;
    logic [15:0]   r_dur;
    logic [31:0]   r_prod;
    logic [CW-1:0] r_i, r_j;

    logic [2:0]    r_pkind;
    logic [15:0]   r_ppid;
    logic [2:0]    r_pdev;
    logic          r_pwait, r_plast;

    logic          r_ovalid;
    logic [2:0]    r_okind;
    logic [15:0]   r_opid;
    logic [2:0]    r_odev;
    logic          r_owait, r_olast;

    logic               w_we;
    logic [AW-1:0]      w_waddr, w_raddr;
    logic [ENTRY_W-1:0] w_wdata, w_rdata;
    logic [32:0]        w_round;
    logic [15:0]        w_ticks;
    logic               w_out_free;
    logic [CW-1:0]      w_roff, w_woff;

    function automatic logic [AW-1:0] slot_addr(input logic [2:0] dev,
                                                input logic [PW-1:0] head,
                                                input logic [CW-1:0] off);
        logic [PW:0] sum;
        begin
            sum = (PW + 1)'(head) + (PW + 1)'(off);
            if (sum >= QD_P) begin
                sum = sum - QD_P;
            end
            slot_addr = AW'(dev) * QD_A + AW'(sum);
        end
    endfunction

    mdios_qram #(.DEPTH(MEM_D), .AW(AW)) u_qram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_round = 33'(r_prod) + 33'd255;
    always_comb begin
        if (r_op == OP_REQ) begin
            if (w_round[32:8] == '0) begin
                w_ticks = 16'd1;
            end else if (w_round[32:24] != '0) begin
                w_ticks = 16'hFFFF;
            end else begin
                w_ticks = w_round[23:8];
            end
        end else begin
            w_ticks = (r_dur == 16'd0) ? 16'd1 : r_dur;
        end
    end

    always_comb begin
        w_roff = (r_state == S_SRD) ? '0 : r_i;
        w_woff = (r_state == S_REQ) ? r_cnt[r_dev] : r_j;
        w_raddr = slot_addr(r_dev, r_head[r_dev], w_roff);
        w_waddr = slot_addr(r_dev, r_head[r_dev], w_woff);
        w_wdata = (r_state == S_REQ) ? {r_pid, w_ticks} : w_rdata;
        w_we = ((r_state == S_REQ) && r_busy[r_dev] && (r_cnt[r_dev] < QD_C)) ||
               ((r_state == S_CCMP) && (w_rdata[31:16] != r_pid));
    end

    assign w_out_free    = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_owait, r_odev, r_opid, r_okind};
    assign m_axis_tlast  = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_sret   <= S_IDLE;
            r_ovalid <= 1'b0;
            r_scale  <= SCALE_RESET;
            for (int k = 0; k < NUM_DEV; k++) begin
                r_lat[k]  <= LAT_RESET;
                r_busy[k] <= 1'b0;
                r_cnt[k]  <= '0;
                r_head[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx < CFG_SCALE) begin
                    r_lat[i_cfg_idx] <= i_cfg_data;
                end else if (i_cfg_idx == CFG_SCALE) begin
                    r_scale <= i_cfg_data;
                end
            end
            if (r_ovalid && m_axis_tready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op    <= s_axis_tdata[2:0];
                        r_pid   <= s_axis_tdata[18:3];
                        r_dev   <= (s_axis_tdata[2:0] inside {OP_REQ, OP_TIMED}) ?
                                   s_axis_tdata[21:19] : 3'd0;
                        r_dur   <= s_axis_tdata[37:22];
                        r_i     <= '0;
                        r_j     <= '0;
                        r_ppid  <= s_axis_tdata[18:3];
                        r_pdev  <= 3'd0;
                        r_pwait <= 1'b0;
                        r_plast <= 1'b1;
                        r_ret   <= S_IDLE;
                        case (s_axis_tdata[2:0])
                            OP_REQ, OP_TIMED: begin
                                if (s_axis_tdata[21:19] > LAST_DEV) begin
                                    r_pkind <= K_REJECT;
                                    r_state <= S_OUT;
                                end else begin
                                    r_state <= S_MUL;
                                end
                            end
                            OP_CANCEL: begin
                                r_state <= S_CRD;
                            end
                            OP_TICK: begin
                                r_state <= S_TDEV;
                            end
                            OP_QUERY: begin
                                r_state <= S_QDEV;
                            end
                            default: begin
                                r_pkind <= K_REJECT;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_prod  <= r_lat[r_dev] * r_scale;
                    r_state <= S_REQ;
                end
                S_REQ: begin
                    r_pdev <= r_dev;
                    if (!r_busy[r_dev]) begin
                        r_busy[r_dev] <= 1'b1;
                        r_cpid[r_dev] <= r_pid;
                        r_rem[r_dev]  <= w_ticks;
                        r_pkind       <= K_ACCEPT;
                    end else if (r_cnt[r_dev] < QD_C) begin
                        r_cnt[r_dev] <= r_cnt[r_dev] + 1'b1;
                        r_pkind      <= K_ACCEPT;
                    end else begin
                        r_pkind <= K_REJECT;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= r_pkind;
                        r_opid   <= r_ppid;
                        r_odev   <= r_pdev;
                        r_owait  <= r_pwait;
                        r_olast  <= r_plast;
                        r_state  <= r_ret;
                    end
                end
                S_SRD: begin
                    r_state <= (r_cnt[r_dev] == '0) ? r_sret : S_SLD;
                end
                S_SLD: begin
                    r_cpid[r_dev] <= w_rdata[31:16];
                    r_rem[r_dev]  <= w_rdata[15:0];
                    r_busy[r_dev] <= 1'b1;
                    r_cnt[r_dev]  <= r_cnt[r_dev] - 1'b1;
                    r_head[r_dev] <= (32'(r_head[r_dev]) == QUEUE_DEPTH - 1) ?
                                     '0 : r_head[r_dev] + 1'b1;
                    r_state <= r_sret;
                end
                S_CRD: begin
                    if (r_i < r_cnt[r_dev]) begin
                        r_state <= S_CCMP;
                    end else begin
                        r_cnt[r_dev] <= r_j;
                        r_state      <= S_CFREE;
                    end
                end
                S_CCMP: begin
                    if (w_rdata[31:16] != r_pid) begin
                        r_j <= r_j + 1'b1;
                    end
                    r_i     <= r_i + 1'b1;
                    r_state <= S_CRD;
                end
                S_CFREE: begin
                    if (r_busy[r_dev] && (r_cpid[r_dev] == r_pid)) begin
                        r_busy[r_dev] <= 1'b0;
                        r_sret        <= S_CNEXT;
                        r_state       <= S_SRD;
                    end else begin
                        r_state <= S_CNEXT;
                    end
                end
                S_CNEXT: begin
                    r_i <= '0;
                    r_j <= '0;
                    if (r_dev == LAST_DEV) begin
                        r_pkind <= K_ACCEPT;
                        r_state <= S_OUT;
                    end else begin
                        r_dev   <= r_dev + 1'b1;
                        r_state <= S_CRD;
                    end
                end
                S_TDEV: begin
                    if (r_busy[r_dev] && (r_rem[r_dev] <= 16'd1)) begin
                        r_rem[r_dev]  <= '0;
                        r_busy[r_dev] <= 1'b0;
                        r_pkind <= K_DONE;
                        r_ppid  <= r_cpid[r_dev];
                        r_pdev  <= r_dev;
                        r_plast <= 1'b0;
                        r_ret   <= S_TSTART;
                        r_state <= S_OUT;
                    end else begin
                        if (r_busy[r_dev]) begin
                            r_rem[r_dev] <= r_rem[r_dev] - 1'b1;
                        end
                        r_state <= S_TNEXT;
                    end
                end
                S_TSTART: begin
                    r_sret  <= S_TNEXT;
                    r_state <= S_SRD;
                end
                S_TNEXT: begin
                    if (r_dev == LAST_DEV) begin
                        r_pkind <= K_TICK;
                        r_ppid  <= '0;
                        r_pdev  <= 3'd0;
                        r_plast <= 1'b1;
                        r_ret   <= S_IDLE;
                        r_state <= S_OUT;
                    end else begin
                        r_dev   <= r_dev + 1'b1;
                        r_state <= S_TDEV;
                    end
                end
                S_QDEV: begin
                    r_i <= '0;
                    if (r_busy[r_dev] && (r_cpid[r_dev] == r_pid)) begin
                        r_pkind <= K_QUERY;
                        r_pdev  <= r_dev;
                        r_pwait <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_QRD;
                    end
                end
                S_QRD: begin
                    if (r_i < r_cnt[r_dev]) begin
                        r_state <= S_QCMP;
                    end else if (r_dev == LAST_DEV) begin
                        r_pkind <= K_QUERY;
                        r_state <= S_OUT;
                    end else begin
                        r_dev   <= r_dev + 1'b1;
                        r_state <= S_QDEV;
                    end
                end
                S_QCMP: begin
                    if (w_rdata[31:16] == r_pid) begin
                        r_pkind <= K_QUERY;
                        r_pdev  <= r_dev;
                        r_pwait <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_QRD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/mdios_checker.sv =====
// ----------------------------------------------------------------------------
// mdios_checker
// port-level checks of the scheduler result stream
// ----------------------------------------------------------------------------
`include "multi_device_io_request_scheduler_defines.svh"

module mdios_checker
    import mdios_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    `MDIOS_ASSERT_IMP(a_done_not_last, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[2:0] == K_DONE), !m_axis_tlast)
    `MDIOS_ASSERT_IMP(a_tick_last, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[2:0] == K_TICK), m_axis_tlast && (m_axis_tdata[18:3] == 16'd0))
    `MDIOS_ASSERT_IMP(a_wait_query, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[22], m_axis_tdata[2:0] == K_QUERY)
    `MDIOS_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind multi_device_io_request_scheduler mdios_checker u_mdios_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// i/o request scheduler: directed table, config extremes, then random traffic under three
// stall patterns, every result checked field by field against a predictor
// ----------------------------------------------------------------------------
module tb_top;
    import mdios_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH = 16;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int EXP_DEPTH = 4096;
    localparam int ROW_DEPTH = 64;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] pid;
        logic [2:0]  dev;
        logic        waiting;
        logic        last;
    } t_result;

    typedef struct {
        logic [2:0]  op;
        logic [15:0] pid;
        logic [2:0]  dev;
        logic [15:0] dur;
        logic        has_exp;
        t_result     exp;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    multi_device_io_request_scheduler dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [15:0] lat [NUM_DEV];
    logic [15:0] scale;
    logic        busy [NUM_DEV];
    logic [15:0] cur_pid [NUM_DEV];
    logic [15:0] cur_rem [NUM_DEV];
    logic [31:0] qmem [NUM_DEV][QDEPTH];
    int          qcnt [NUM_DEV];

    t_result exp_q [EXP_DEPTH];
    int      exp_wr = 0;
    int      exp_rd = 0;
    int      failures = 0;
    int      cycles = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;

    function automatic void exp_put(t_result r);
        exp_q[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endfunction

    function automatic t_result exp_take();
        t_result r;
        r = exp_q[exp_rd % EXP_DEPTH];
        exp_rd++;
        return r;
    endfunction

    function automatic logic [15:0] fixed_ticks(int d);
        logic [32:0] t;
        t = ({17'd0, lat[d]} * {17'd0, scale} + 33'd255) >> 8;
        if (t == 0) t = 1;
        if (t > 33'hffff) t = 33'hffff;
        return t[15:0];
    endfunction

    function automatic void start_next(int d);
        if (busy[d] || qcnt[d] == 0) return;
        cur_pid[d] = qmem[d][0][31:16];
        cur_rem[d] = qmem[d][0][15:0];
        for (int i = 1; i < qcnt[d]; i++) qmem[d][i-1] = qmem[d][i];
        qcnt[d]--;
        busy[d] = 1'b1;
    endfunction

    function automatic t_result mk(logic [2:0] k, logic [15:0] p, logic [2:0] dv,
                                   logic w, logic l);
        t_result r;
        r.kind = k; r.pid = p; r.dev = dv; r.waiting = w; r.last = l;
        return r;
    endfunction

    function automatic void predict_schedule(logic [2:0] op, logic [15:0] pid,
                                             logic [2:0] dev, logic [15:0] dur);
        logic [15:0] ticks;
        int j;
        logic hit;
        case (op)
            OP_REQ, OP_TIMED: begin
                if (dev >= NUM_DEV) begin
                    exp_put(mk(K_REJECT, pid, 3'd0, 0, 1));
                    return;
                end
                ticks = (op == OP_REQ) ? fixed_ticks(dev) : (dur == 0 ? 16'd1 : dur);
                if (!busy[dev]) begin
                    busy[dev] = 1'b1; cur_pid[dev] = pid; cur_rem[dev] = ticks;
                end else if (qcnt[dev] < QDEPTH) begin
                    qmem[dev][qcnt[dev]] = {pid, ticks};
                    qcnt[dev]++;
                end else begin
                    exp_put(mk(K_REJECT, pid, dev, 0, 1));
                    return;
                end
                exp_put(mk(K_ACCEPT, pid, dev, 0, 1));
            end
            OP_CANCEL: begin
                for (int d = 0; d < NUM_DEV; d++) begin
                    j = 0;
                    for (int i = 0; i < qcnt[d]; i++)
                        if (qmem[d][i][31:16] != pid) begin
                            qmem[d][j] = qmem[d][i]; j++;
                        end
                    qcnt[d] = j;
                    if (busy[d] && cur_pid[d] == pid) begin
                        busy[d] = 1'b0;
                        start_next(d);
                    end
                end
                exp_put(mk(K_ACCEPT, pid, 3'd0, 0, 1));
            end
            OP_TICK: begin
                for (int d = 0; d < NUM_DEV; d++) begin
                    if (!busy[d]) continue;
                    if (cur_rem[d] <= 1) begin
                        cur_rem[d] = 0;
                        exp_put(mk(K_DONE, cur_pid[d], d[2:0], 0, 0));
                        busy[d] = 1'b0;
                        start_next(d);
                    end else cur_rem[d]--;
                end
                exp_put(mk(K_TICK, 16'd0, 3'd0, 0, 1));
            end
            OP_QUERY: begin
                for (int d = 0; d < NUM_DEV; d++) begin
                    hit = busy[d] && cur_pid[d] == pid;
                    for (int i = 0; i < qcnt[d]; i++)
                        if (qmem[d][i][31:16] == pid) hit = 1'b1;
                    if (hit) begin
                        exp_put(mk(K_QUERY, pid, d[2:0], 1, 1));
                        return;
                    end
                end
                exp_put(mk(K_QUERY, pid, 3'd0, 0, 1));
            end
            default: exp_put(mk(K_REJECT, pid, 3'd0, 0, 1));
        endcase
    endfunction

    // result checking and receiver stalls
    always @(posedge i_clk) begin
        t_result got, want;
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = mk(m_axis_tdata[2:0], m_axis_tdata[18:3], m_axis_tdata[21:19],
                     m_axis_tdata[22], m_axis_tlast);
            if (exp_wr == exp_rd) begin
                $error("unexpected result kind=%0d pid=%0d", got.kind, got.pid);
                failures++;
            end else begin
                want = exp_take();
                if (got.kind !== want.kind) begin
                    $error("kind exp %0d got %0d", want.kind, got.kind); failures++;
                end
                if (got.pid !== want.pid) begin
                    $error("out_pid exp %0d got %0d", want.pid, got.pid); failures++;
                end
                if (got.dev !== want.dev) begin
                    $error("out_device exp %0d got %0d", want.dev, got.dev); failures++;
                end
                if (got.waiting !== want.waiting) begin
                    $error("waiting exp %0d got %0d", want.waiting, got.waiting);
                    failures++;
                end
                if (got.last !== want.last) begin
                    $error("last exp %0d got %0d", want.last, got.last); failures++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_item(logic [2:0] op, logic [15:0] pid, logic [2:0] dev,
                             logic [15:0] dur);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, dur, dev, pid, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_schedule(op, pid, dev, dur);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx < NUM_DEV) lat[idx] = val;
        else if (idx == CFG_SCALE) scale = val;
        @(posedge i_clk);
    endtask

    // a few live pids so cancel and query hit often
    function automatic logic [15:0] pick_pid();
        if ($urandom_range(3) == 0) return 16'($urandom);
        return 16'($urandom_range(7)) | ($urandom_range(1) ? 16'hfff8 : 16'h0000);
    endfunction

    task automatic random_phase(int n);
        logic [2:0] op;
        logic [2:0] dv;
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            op = r < 30 ? OP_REQ : r < 50 ? OP_TIMED : r < 60 ? OP_CANCEL :
                 r < 85 ? OP_TICK : r < 96 ? OP_QUERY : 3'($urandom_range(7));
            dv = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
            send_item(op, pick_pid(), dv,
                      $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(4)));
        end
    endtask

    t_row rows [ROW_DEPTH];
    int   row_cnt = 0;

    task automatic add_row(logic [2:0] op, logic [15:0] pid, logic [2:0] dev,
                           logic [15:0] dur, logic he, t_result e);
        t_row r;
        r.op = op; r.pid = pid; r.dev = dev; r.dur = dur; r.has_exp = he; r.exp = e;
        rows[row_cnt] = r;
        row_cnt++;
    endtask

    initial begin
        t_result none;
        none = '0;
        for (int d = 0; d < NUM_DEV; d++) begin
            lat[d] = LAT_RESET; busy[d] = 0; qcnt[d] = 0;
        end
        scale = SCALE_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(OP_QUERY, 16'hffff, 0, 0, 1, mk(K_QUERY, 16'hffff, 0, 0, 1));
        add_row(OP_TICK, 0, 0, 0, 1, mk(K_TICK, 0, 0, 0, 1));
        add_row(OP_REQ, 16'h1234, 3'd7, 0, 1, mk(K_REJECT, 16'h1234, 0, 0, 1));
        add_row(OP_TIMED, 16'h0001, 3'd5, 16'hffff, 1, mk(K_REJECT, 16'h0001, 0, 0, 1));
        add_row(3'd5, 16'hffff, 0, 0, 1, mk(K_REJECT, 16'hffff, 0, 0, 1));
        add_row(3'd7, 16'h0000, 3'd7, 16'hffff, 1, mk(K_REJECT, 0, 0, 0, 1));
        add_row(OP_TIMED, 16'h0000, 3'd4, 16'h0000, 1, mk(K_ACCEPT, 0, 4, 0, 1));
        add_row(OP_TIMED, 16'hffff, 3'd4, 16'hffff, 1, mk(K_ACCEPT, 16'hffff, 4, 0, 1));
        add_row(OP_REQ, 16'h00aa, 3'd0, 0, 1, mk(K_ACCEPT, 16'h00aa, 0, 0, 1));
        add_row(OP_QUERY, 16'hffff, 0, 0, 1, mk(K_QUERY, 16'hffff, 4, 1, 1));
        add_row(OP_TICK, 0, 0, 0, 0, none);
        add_row(OP_TICK, 0, 0, 0, 0, none);
        add_row(OP_CANCEL, 16'h00aa, 3'd7, 0, 1, mk(K_ACCEPT, 16'h00aa, 0, 0, 1));
        add_row(OP_CANCEL, 16'hffff, 0, 0, 1, mk(K_ACCEPT, 16'hffff, 0, 0, 1));
        add_row(OP_QUERY, 16'hffff, 0, 0, 0, none);
        for (int i = 0; i < 18; i++)
            add_row(OP_TIMED, 16'(16'h0100 + i), 3'd2, 16'd3, 0, none);
        add_row(OP_QUERY, 16'h0110, 0, 0, 0, none);
        add_row(OP_CANCEL, 16'h0100, 0, 0, 0, none);
        add_row(OP_TICK, 0, 0, 0, 0, none);

        for (int i = 0; i < row_cnt; i++) begin
            send_item(rows[i].op, rows[i].pid, rows[i].dev, rows[i].dur);
            if (rows[i].has_exp && exp_q[(exp_wr - 1) % EXP_DEPTH] !== rows[i].exp) begin
                $error("table row %0d: model disagrees with typed result", i);
                failures++;
            end
        end
        drain();

        // extremes: zero scale, zero latency, saturating product
        write_reg(CFG_SCALE, 16'd0);
        for (int d = 0; d < NUM_DEV; d++) write_reg(d[2:0], 16'hffff);
        for (int d = 0; d < NUM_DEV; d++) send_item(OP_REQ, 16'(d), d[2:0], 0);
        drain();
        write_reg(CFG_SCALE, 16'hffff);
        for (int d = 0; d < NUM_DEV; d++) send_item(OP_REQ, 16'(d), d[2:0], 0);
        for (int d = 0; d < NUM_DEV; d++) send_item(OP_CANCEL, 16'(d), 0, 0);
        drain();
        write_reg(3'd0, 16'd0);
        send_item(OP_REQ, 16'h0042, 0, 0);
        send_item(OP_TICK, 0, 0, 0);
        drain();

        send_idle_pct = 24; recv_idle_pct = 50;
        write_reg(CFG_SCALE, 16'd128);
        for (int d = 0; d < NUM_DEV; d++) write_reg(d[2:0], 16'($urandom_range(1, 6)));
        random_phase(50);
        drain();
        send_idle_pct = 50; recv_idle_pct = 24;
        write_reg(CFG_SCALE, 16'd700);
        for (int d = 0; d < NUM_DEV; d++) write_reg(d[2:0], 16'($urandom_range(0, 3)));
        random_phase(50);
        drain();
        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(CFG_SCALE, SCALE_RESET);
        random_phase(50);
        drain();

        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
